// File: src/cbsm_pkg.sv
`default_nettype none
package cbsm_pkg;

  // Time results are Q8.8 seconds, saturated at this width.
  localparam int unsigned TIME_W   = 16;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Input and register field widths.
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned ROAD_W   = 9;
  localparam int unsigned GEAR_W   = 2;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned MODE_W   = 3;

  // Shared divider operand widths.
  localparam int unsigned DVD_W    = 32;              // speed << 16, distance << 12
  localparam int unsigned DVS_W    = CFG_W + ROAD_W;  // decel * road
  localparam int unsigned CNT_W    = $clog2(TIME_W);

  // Margin products: margin (16) times a warning time (17).
  localparam int unsigned WARN_W   = TIME_W + 1;
  localparam int unsigned PROD_W   = CFG_W + WARN_W;

  localparam logic [GEAR_W-1:0] GEAR_DRIVE   = 2'd1;
  localparam logic [GEAR_W-1:0] GEAR_REVERSE = 2'd2;

  // Which time a divider result is stored as.
  typedef enum logic [1:0] {
    TS_TTC,
    TS_PB,
    TS_FB
  } time_sel_e;

  // Which time the margin multiplies.
  typedef enum logic [1:0] {
    MS_WARN,
    MS_PB,
    MS_FB
  } marg_sel_e;

  typedef struct packed {
    logic      load;       // capture the input item
    logic      mul_den;    // form decel * road
    logic      den_full;   // use full_decel rather than partial_decel
    logic      div_start;  // launch the shared divider
    logic      div_stop;   // stopping-time operands, else time to collision
    logic      store;      // store the divider result
    time_sel_e store_sel;
    logic      mprod;      // form margin * time
    marg_sel_e mprod_sel;
    logic      mcmp;       // compare ttc against the last margin product
    logic      update;     // step the braking mode and load the result
  } cbsm_cmd_t;

endpackage
`default_nettype wire

// File: src/cbsm_div.sv
`default_nettype none
module cbsm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cbsm_pkg::DVD_W-1:0]   dividend_i,
  input  logic [cbsm_pkg::DVS_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [cbsm_pkg::TIME_W-1:0]  quotient_o
);
  import cbsm_pkg::*;

  localparam int unsigned CMP_W = DVS_W + TIME_W;

  logic                busy_q;
  logic                done_q;
  logic                sat_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [DVS_W-1:0]    rem_q;
  logic [DVS_W-1:0]    dvs_q;
  logic [TIME_W-1:0]   lo_q;

  logic                sat;
  logic [DVS_W:0]      trial;
  logic                ge;
  logic [DVS_W-1:0]    rem_nx;
  logic [DVS_W:0]      diff;

  // Quotient wider than TIME_W bits (or a zero divisor): saturate at once.
  assign sat = {{(CMP_W-DVD_W){1'b0}}, dividend_i} >= {divisor_i, {TIME_W{1'b0}}};

  // One restoring step per cycle.
  assign trial  = {rem_q, lo_q[TIME_W-1]};
  assign ge     = trial >= {1'b0, dvs_q};
  assign diff   = trial - {1'b0, dvs_q};
  assign rem_nx = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (sat) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(TIME_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sat_q <= sat;
      dvs_q <= divisor_i;
      rem_q <= {{(DVS_W-(DVD_W-TIME_W)){1'b0}}, dividend_i[DVD_W-1:TIME_W]};
      lo_q  <= dividend_i[TIME_W-1:0];
    end else if (busy_q) begin
      rem_q <= rem_nx;
      lo_q  <= {lo_q[TIME_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = sat_q ? TIME_MAX : lo_q;

endmodule
`default_nettype wire

// File: src/cbsm_datapath.sv
`default_nettype none
module cbsm_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cbsm_pkg::cbsm_cmd_t          cmd_i,
  output logic                         div_done_o,
  input  logic [cbsm_pkg::SPEED_W-1:0] speed_i,
  input  logic [cbsm_pkg::DIST_W-1:0]  distance_i,
  input  logic [cbsm_pkg::ROAD_W-1:0]  road_factor_i,
  input  logic [cbsm_pkg::GEAR_W-1:0]  gear_i,
  input  logic                         pedal_i,
  input  logic [cbsm_pkg::CFG_W-1:0]   reaction_time_i,
  input  logic [cbsm_pkg::CFG_W-1:0]   partial_decel_i,
  input  logic [cbsm_pkg::CFG_W-1:0]   full_decel_i,
  input  logic [cbsm_pkg::CFG_W-1:0]   margin_i,
  output logic [cbsm_pkg::MODE_W-1:0]  next_mode_o,
  output logic [cbsm_pkg::TIME_W-1:0]  time_to_collision_o,
  output logic [cbsm_pkg::TIME_W-1:0]  partial_stop_time_o,
  output logic [cbsm_pkg::TIME_W-1:0]  full_stop_time_o
);
  import cbsm_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE = 3'd0,
    MODE_FWD  = 3'd1,
    MODE_PART = 3'd2,
    MODE_FULL = 3'd3,
    MODE_REV  = 3'd4
  } mode_e;

  logic [SPEED_W-1:0] spd_q;
  logic [DIST_W-1:0]  dist_q;
  logic [ROAD_W-1:0]  road_q;
  logic [GEAR_W-1:0]  gear_q;
  logic               pedal_q;
  logic [DVS_W-1:0]   den_q;
  logic [TIME_W-1:0]  ttc_q, pb_q, fb_q;
  logic [PROD_W-1:0]  prod_q;
  marg_sel_e          msel_q;
  logic               bw_q, bp_q, bf_q;
  mode_e              mode_q, mode_d;

  logic [CFG_W-1:0]   decel;
  logic [DVD_W-1:0]   dividend;
  logic [DVS_W-1:0]   divisor;
  logic [TIME_W-1:0]  quo;
  logic [TIME_W:0]    stop_sum;
  logic [TIME_W-1:0]  stop_sat;
  logic [WARN_W-1:0]  warn;
  logic [WARN_W-1:0]  mtime;
  logic               beyond;
  logic               le_warn, le_pb, le_fb;
  logic               drive, rev;

  assign decel = cmd_i.den_full ? full_decel_i : partial_decel_i;

  always_comb begin
    if (cmd_i.div_stop) begin
      dividend = {spd_q, 16'd0};
      divisor  = den_q;
    end else begin
      dividend = {4'd0, dist_q, 12'd0};
      divisor  = {{(DVS_W-SPEED_W){1'b0}}, spd_q};
    end
  end

  cbsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done_o),
    .quotient_o (quo)
  );

  // Add reaction time to a stopping quotient, saturating.
  assign stop_sum = {1'b0, quo} + {1'b0, reaction_time_i};
  assign stop_sat = stop_sum[TIME_W] ? TIME_MAX : stop_sum[TIME_W-1:0];

  assign warn = {1'b0, pb_q} + {1'b0, margin_i};

  always_comb begin
    case (cmd_i.mprod_sel)
      MS_WARN: mtime = warn;
      MS_PB:   mtime = {1'b0, pb_q};
      MS_FB:   mtime = {1'b0, fb_q};
      default: mtime = warn;
    endcase
  end

  // ttc exceeds margin times t, both Q8.8: ttc * 256 > margin * t.
  assign beyond = {{(PROD_W-TIME_W-8){1'b0}}, ttc_q, 8'd0} > prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      spd_q   <= speed_i;
      dist_q  <= distance_i;
      road_q  <= road_factor_i;
      gear_q  <= gear_i;
      pedal_q <= pedal_i;
    end
    if (cmd_i.mul_den) begin
      den_q <= {{ROAD_W{1'b0}}, decel} * {{CFG_W{1'b0}}, road_q};
    end
    if (cmd_i.store) begin
      case (cmd_i.store_sel)
        TS_TTC:  ttc_q <= quo;
        TS_PB:   pb_q  <= stop_sat;
        TS_FB:   fb_q  <= stop_sat;
        default: ttc_q <= quo;
      endcase
    end
    if (cmd_i.mprod) begin
      prod_q <= {{WARN_W{1'b0}}, margin_i} * {{CFG_W{1'b0}}, mtime};
      msel_q <= cmd_i.mprod_sel;
    end
    if (cmd_i.mcmp) begin
      case (msel_q)
        MS_WARN: bw_q <= beyond;
        MS_PB:   bp_q <= beyond;
        MS_FB:   bf_q <= beyond;
        default: bw_q <= beyond;
      endcase
    end
    if (cmd_i.update) begin
      next_mode_o         <= mode_d;
      time_to_collision_o <= ttc_q;
      partial_stop_time_o <= pb_q;
      full_stop_time_o    <= fb_q;
    end
  end

  assign le_warn = {1'b0, ttc_q} <= warn;
  assign le_pb   = ttc_q <= pb_q;
  assign le_fb   = ttc_q <= fb_q;
  assign drive   = gear_q == GEAR_DRIVE;
  assign rev     = gear_q == GEAR_REVERSE;

  always_comb begin
    case (mode_q)
      MODE_IDLE: begin
        if (le_warn && drive)    mode_d = MODE_FWD;
        else if (le_warn && rev) mode_d = MODE_REV;
        else                     mode_d = MODE_IDLE;
      end
      MODE_FWD: begin
        if (le_pb && !pedal_q) mode_d = MODE_PART;
        else if (bw_q)         mode_d = MODE_IDLE;
        else                   mode_d = MODE_FWD;
      end
      MODE_PART: begin
        if (le_fb)               mode_d = MODE_FULL;
        else if (bp_q || pedal_q) mode_d = MODE_FWD;
        else                     mode_d = MODE_PART;
      end
      MODE_FULL: begin
        if (le_fb)                              mode_d = MODE_FULL;
        else if ((bp_q && rev) || (pedal_q && rev)) mode_d = MODE_REV;
        else if (bf_q && drive)                 mode_d = MODE_PART;
        else if (pedal_q && drive)              mode_d = MODE_FWD;
        else                                    mode_d = MODE_FULL;
      end
      MODE_REV: begin
        if (le_pb && !pedal_q) mode_d = MODE_FULL;
        else if (bw_q)         mode_d = MODE_IDLE;
        else                   mode_d = MODE_REV;
      end
      default: mode_d = MODE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else if (cmd_i.update) begin
      mode_q <= mode_d;
    end
  end

endmodule
`default_nettype wire

// File: src/cbsm_ctrl.sv
`default_nettype none
module cbsm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic                div_done_i,
  output cbsm_pkg::cbsm_cmd_t cmd_o
);
  import cbsm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TTC_GO,
    S_TTC_WAIT,
    S_PB_GO,
    S_PB_WAIT,
    S_FB_GO,
    S_FB_WAIT,
    S_MW,
    S_MP,
    S_MF,
    S_CF,
    S_UPD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_TTC_GO;
        end
      end
      S_TTC_GO: begin
        // Partial-brake divisor forms while the ttc division runs.
        cmd_o.div_start = 1'b1;
        cmd_o.mul_den   = 1'b1;
        state_d         = S_TTC_WAIT;
      end
      S_TTC_WAIT: begin
        if (div_done_i) begin
          cmd_o.store     = 1'b1;
          cmd_o.store_sel = TS_TTC;
          state_d         = S_PB_GO;
        end
      end
      S_PB_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_stop  = 1'b1;
        state_d         = S_PB_WAIT;
      end
      S_PB_WAIT: begin
        cmd_o.div_stop = 1'b1;
        if (div_done_i) begin
          cmd_o.store     = 1'b1;
          cmd_o.store_sel = TS_PB;
          cmd_o.mul_den   = 1'b1;
          cmd_o.den_full  = 1'b1;
          state_d         = S_FB_GO;
        end
      end
      S_FB_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_stop  = 1'b1;
        state_d         = S_FB_WAIT;
      end
      S_FB_WAIT: begin
        cmd_o.div_stop = 1'b1;
        if (div_done_i) begin
          cmd_o.store     = 1'b1;
          cmd_o.store_sel = TS_FB;
          state_d         = S_MW;
        end
      end
      S_MW: begin
        cmd_o.mprod     = 1'b1;
        cmd_o.mprod_sel = MS_WARN;
        state_d         = S_MP;
      end
      S_MP: begin
        cmd_o.mprod     = 1'b1;
        cmd_o.mprod_sel = MS_PB;
        cmd_o.mcmp      = 1'b1;
        state_d         = S_MF;
      end
      S_MF: begin
        cmd_o.mprod     = 1'b1;
        cmd_o.mprod_sel = MS_FB;
        cmd_o.mcmp      = 1'b1;
        state_d         = S_CF;
      end
      S_CF: begin
        cmd_o.mcmp = 1'b1;
        state_d    = S_UPD;
      end
      S_UPD: begin
        // Hold until the output register is free.
        if (slot_free) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.update) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_TTC_GO)
    else $error("accepted item did not start the ttc division");

  a_valid_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_UPD))
    else $error("result raised outside the update step");

  a_upd_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && out_valid_q && !out_ready_i) |=> state_q == S_UPD)
    else $error("update overwrote a pending result");
`endif

endmodule
`default_nettype wire

// File: src/collision_braking_state_machine.sv
`default_nettype none
// Emergency braking decision block. Each input transfer carries speed, obstacle
// distance, road friction, gear and brake pedal; each output transfer returns the
// new braking mode with the time to collision and the partial- and full-brake
// stopping times (Q8.8 seconds, saturated at all ones). One item is in work at a
// time: the block is ready for the next input transfer once the result of the
// last item is loaded. The time is set by three 16-step divisions on one shared
// restoring divider (a division ends early when its quotient saturates) plus the
// margin multiply-compare steps and the update. The result sits in an output
// register, so the next item is taken while a result still waits; a stalled
// result holds the block only at its final update step. Registers are to be
// written over the APB port only while no item is in work; the block itself
// does not enforce this.
module collision_braking_state_machine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream: speed[15:0], distance[31:16], road_factor[40:32],
  // gear[42:41], pedal[43], zero[47:44]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  // Output stream: next_mode[2:0], time_to_collision[18:3],
  // partial_stop_time[34:19], full_stop_time[50:35], zero[55:51]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cbsm_pkg::*;

  localparam logic [1:0] REG_REACTION = 2'd0;
  localparam logic [1:0] REG_PARTIAL  = 2'd1;
  localparam logic [1:0] REG_FULL     = 2'd2;
  localparam logic [1:0] REG_MARGIN   = 2'd3;

  logic [CFG_W-1:0] reaction_q, partial_q, full_q, margin_q;
  logic             cfg_wr;
  cbsm_cmd_t        cmd;
  logic             div_done;

  logic [MODE_W-1:0] next_mode;
  logic [TIME_W-1:0] ttc, pst, fst;

  // APB: zero wait states; write on the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reaction_q <= 16'd256;
      partial_q  <= 16'd1024;
      full_q     <= 16'd2048;
      margin_q   <= 16'd256;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_REACTION: reaction_q <= pwdata[CFG_W-1:0];
        REG_PARTIAL:  partial_q  <= pwdata[CFG_W-1:0];
        REG_FULL:     full_q     <= pwdata[CFG_W-1:0];
        REG_MARGIN:   margin_q   <= pwdata[CFG_W-1:0];
        default:      reaction_q <= reaction_q;
      endcase
    end
  end

  // Read back the addressed register, upper half zero.
  always_comb begin
    case (paddr[3:2])
      REG_REACTION: prdata = {16'd0, reaction_q};
      REG_PARTIAL:  prdata = {16'd0, partial_q};
      REG_FULL:     prdata = {16'd0, full_q};
      REG_MARGIN:   prdata = {16'd0, margin_q};
      default:      prdata = '0;
    endcase
  end

  // Sequencer: owns the handshakes and the step order.
  cbsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .div_done_i  (div_done),
    .cmd_o       (cmd)
  );

  // Datapath: operand capture, divider, margin products, braking mode.
  cbsm_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .div_done_o          (div_done),
    .speed_i             (s_axis_tdata[15:0]),
    .distance_i          (s_axis_tdata[31:16]),
    .road_factor_i       (s_axis_tdata[40:32]),
    .gear_i              (s_axis_tdata[42:41]),
    .pedal_i             (s_axis_tdata[43]),
    .reaction_time_i     (reaction_q),
    .partial_decel_i     (partial_q),
    .full_decel_i        (full_q),
    .margin_i            (margin_q),
    .next_mode_o         (next_mode),
    .time_to_collision_o (ttc),
    .partial_stop_time_o (pst),
    .full_stop_time_o    (fst)
  );

  assign m_axis_tdata = {5'd0, fst, pst, ttc, next_mode};

endmodule
`default_nettype wire

// File: sim/tb.sv
`default_nettype none
module tb;
  import cbsm_pkg::*;

  // Braking modes as reported in next_mode.
  localparam logic [MODE_W-1:0] MODE_IDLE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FWD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PART = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FULL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REV  = 3'd4;

  localparam logic [GEAR_W-1:0] GEAR_OTHER_LO = 2'd0;
  localparam logic [GEAR_W-1:0] GEAR_OTHER_HI = 2'd3;

  // Register indexes; each register sits at byte address 4*index.
  localparam int REG_REACTION = 0;
  localparam int REG_PART_DEC = 1;
  localparam int REG_FULL_DEC = 2;
  localparam int REG_MARGIN   = 3;

  localparam longint unsigned TMAX = 64'hFFFF;

  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PH   = 175;
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_AT_RESULT = 150;
  localparam int HOLD_CYCLES    = 600;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [DIST_W-1:0]  distance;
    logic [ROAD_W-1:0]  road;
    logic [GEAR_W-1:0]  gear;
    logic               pedal;
  } reading_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] ttc;
    logic [TIME_W-1:0] pb;
    logic [TIME_W-1:0] fb;
  } decision_t;

  typedef struct packed {
    reading_t  rd;
    logic      typed;
    decision_t want;
  } drow_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  collision_braking_state_machine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the braking state and the registers, kept in step with the block.
  logic [MODE_W-1:0] brake_mode  = MODE_IDLE;
  longint unsigned   reaction_tm = 256;
  longint unsigned   part_decel  = 1024;
  longint unsigned   full_decel  = 2048;
  longint unsigned   margin_q88  = 256;

  decision_t pending_decisions[$];
  drow_t     directed_rows[$];
  int        mismatch_cnt = 0;
  bit        sender_calm  = 1'b0;

  // Stopping time plus reaction, Q8.8 seconds, saturated at every step.
  function automatic longint unsigned stop_time_q88(longint unsigned spd,
                                                    longint unsigned decel,
                                                    longint unsigned road);
    longint unsigned den, t;
    den = decel * road;
    if (den == 0) return TMAX;
    t = (spd << 16) / den;
    if (t > TMAX) t = TMAX;
    t = t + reaction_tm;
    return (t > TMAX) ? TMAX : t;
  endfunction

  // True when ttc exceeds margin times t, both Q8.8.
  function automatic bit exceeds_margin(longint unsigned ttc, longint unsigned t);
    return (ttc << 8) > margin_q88 * t;
  endfunction

  // Work out the decision for one reading and advance the shadow mode.
  function automatic decision_t predict_braking(reading_t rd);
    longint unsigned   ttc, pb, fb, warn;
    logic [MODE_W-1:0] nxt;
    bit                drive, rev, pressed;
    decision_t         d;
    drive   = (rd.gear == GEAR_DRIVE);
    rev     = (rd.gear == GEAR_REVERSE);
    pressed = rd.pedal;
    if (rd.speed == 0) ttc = TMAX;
    else begin
      ttc = (longint'(rd.distance) << 12) / rd.speed;
      if (ttc > TMAX) ttc = TMAX;
    end
    pb   = stop_time_q88(rd.speed, part_decel, rd.road);
    fb   = stop_time_q88(rd.speed, full_decel, rd.road);
    warn = pb + margin_q88;   // one bit wider, no saturation
    case (brake_mode)
      MODE_IDLE: begin
        if (ttc <= warn && drive) nxt = MODE_FWD;
        else if (ttc <= warn && rev) nxt = MODE_REV;
        else nxt = MODE_IDLE;
      end
      MODE_FWD: begin
        if (ttc <= pb && !pressed) nxt = MODE_PART;
        else if (exceeds_margin(ttc, warn)) nxt = MODE_IDLE;
        else nxt = MODE_FWD;
      end
      MODE_PART: begin
        if (ttc <= fb) nxt = MODE_FULL;
        else if (exceeds_margin(ttc, pb) || pressed) nxt = MODE_FWD;
        else nxt = MODE_PART;
      end
      MODE_FULL: begin
        if (ttc <= fb) nxt = MODE_FULL;
        else if ((exceeds_margin(ttc, pb) || pressed) && rev) nxt = MODE_REV;
        else if (exceeds_margin(ttc, fb) && drive) nxt = MODE_PART;
        else if (pressed && drive) nxt = MODE_FWD;
        else nxt = MODE_FULL;
      end
      MODE_REV: begin
        if (ttc <= pb && !pressed) nxt = MODE_FULL;
        else if (exceeds_margin(ttc, warn)) nxt = MODE_IDLE;
        else nxt = MODE_REV;
      end
      default: nxt = MODE_IDLE;
    endcase
    brake_mode = nxt;
    d.mode = nxt;
    d.ttc  = ttc[TIME_W-1:0];
    d.pb   = pb[TIME_W-1:0];
    d.fb   = fb[TIME_W-1:0];
    return d;
  endfunction

  // Mostly short gaps, a few long ones; none at all in a calm stretch.
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Random reading, mostly placed so that the time to collision lands near one
  // of the thresholds the braking machine compares against.
  function automatic reading_t random_reading();
    reading_t        rd;
    longint unsigned pb, fb, warn, target, d;
    int              r, jitter;
    r = $urandom_range(0, 99);
    if (r < 4) rd.speed = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    else if (r < 6) rd.speed = 16'h0001;
    else if (r < 20) rd.speed = 16'($urandom_range(0, 65535));
    else rd.speed = 16'($urandom_range(256, 12000));
    r = $urandom_range(0, 99);
    if (r < 6) rd.road = '0;
    else if (r < 18) rd.road = 9'd256;
    else if (r < 28) rd.road = 9'($urandom_range(1, 63));
    else rd.road = 9'($urandom_range(64, 256));
    r = $urandom_range(0, 99);
    if (r < 40) rd.gear = GEAR_DRIVE;
    else if (r < 75) rd.gear = GEAR_REVERSE;
    else rd.gear = ($urandom_range(0, 1) != 0) ? GEAR_OTHER_HI : GEAR_OTHER_LO;
    rd.pedal = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 99) < 15) begin
      rd.distance = 16'($urandom_range(0, 65535));
      return rd;
    end
    pb   = stop_time_q88(rd.speed, part_decel, rd.road);
    fb   = stop_time_q88(rd.speed, full_decel, rd.road);
    warn = pb + margin_q88;
    case ($urandom_range(0, 5))
      0: target = pb;
      1: target = fb;
      2: target = warn;
      3: target = (margin_q88 * pb) >> 8;
      4: target = (margin_q88 * fb) >> 8;
      default: target = (margin_q88 * warn) >> 8;
    endcase
    jitter = int'($urandom_range(0, 8)) - 4;
    if (jitter < 0) begin
      if (target < longint'(-jitter)) target = 0;
      else target = target - longint'(-jitter);
    end else begin
      target = target + longint'(jitter);
    end
    d = ((target * rd.speed) >> 12) + $urandom_range(0, 1);
    rd.distance = (d > 65535) ? 16'hFFFF : d[15:0];
    return rd;
  endfunction

  task automatic add_row(input logic [15:0] spd, input logic [15:0] dst,
                         input logic [8:0] road, input logic [1:0] gear,
                         input logic pedal, input logic typed,
                         input logic [2:0] mode, input logic [15:0] ttc,
                         input logic [15:0] pb, input logic [15:0] fb);
    drow_t row;
    row.rd    = '{speed: spd, distance: dst, road: road, gear: gear, pedal: pedal};
    row.typed = typed;
    row.want  = '{mode: mode, ttc: ttc, pb: pb, fb: fb};
    directed_rows.push_back(row);
  endtask

  // Offer one reading and hold it until the transfer; then record what it
  // should produce. A typed row overrides the prediction for the check.
  task automatic send_reading(input reading_t rd, input logic typed,
                              input decision_t want);
    int        gap;
    decision_t d;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, rd.pedal, rd.gear, rd.road, rd.distance, rd.speed};
    do @(posedge clk_i); while (!s_axis_tready);
    d = predict_braking(rd);
    pending_decisions.push_back(typed ? want : d);
  endtask

  // Drop valid, wait for every decision, then let the last item finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_decisions.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input int idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx * 4);
    pwdata  <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_REACTION: reaction_tm = value;
      REG_PART_DEC: part_decel  = value;
      REG_FULL_DEC: full_decel  = value;
      REG_MARGIN:   margin_q88  = value;
      default: ;
    endcase
  endtask

  // Settings per phase: minimum, maximum, a fixed mid setting, random ones,
  // and finally back to the reset values.
  task automatic apply_phase_config(input int ph);
    logic [15:0] react, pdec, fdec, marg;
    case (ph)
      1: begin react = 16'd0; pdec = 16'd1; fdec = 16'd1; marg = 16'd0; end
      2: begin react = 16'hFFFF; pdec = 16'hFFFF; fdec = 16'hFFFF; marg = 16'hFFFF; end
      3: begin react = 16'd128; pdec = 16'd512; fdec = 16'd4096; marg = 16'd384; end
      PHASES: begin react = 16'd256; pdec = 16'd1024; fdec = 16'd2048; marg = 16'd256; end
      default: begin
        react = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 2048));
        pdec  = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 65535))
                                            : 16'($urandom_range(128, 8192));
        fdec  = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 65535))
                                            : 16'($urandom_range(128, 8192));
        marg  = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 1024));
      end
    endcase
    write_reg(REG_REACTION, react);
    write_reg(REG_PART_DEC, pdec);
    write_reg(REG_FULL_DEC, fdec);
    write_reg(REG_MARGIN, marg);
  endtask

  // Receiver: random stalls, one long hold-off so the block backs up and
  // stalls its input, then compare each transfer against the oldest decision.
  initial begin : result_side
    int        stall;
    int        taken;
    bit        recv_calm;
    decision_t got, want;
    taken     = 0;
    recv_calm = 1'b0;
    forever begin
      if (taken % 64 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      stall = (taken == HOLD_AT_RESULT) ? HOLD_CYCLES : pick_gap(recv_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
      got.mode = m_axis_tdata[2:0];
      got.ttc  = m_axis_tdata[18:3];
      got.pb   = m_axis_tdata[34:19];
      got.fb   = m_axis_tdata[50:35];
      if (pending_decisions.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected decision: mode %0d ttc %0d pb %0d fb %0d",
                   got.mode, got.ttc, got.pb, got.fb);
      end else begin
        want = pending_decisions.pop_front();
        if (got.mode !== want.mode || got.ttc !== want.ttc ||
            got.pb !== want.pb || got.fb !== want.fb) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display({"decision %0d mismatch: exp mode %0d ttc %0d pb %0d fb %0d,",
                      " got mode %0d ttc %0d pb %0d fb %0d"},
                     taken, want.mode, want.ttc, want.pb, want.fb,
                     got.mode, got.ttc, got.pb, got.fb);
        end
      end
    end
  end

  initial begin : stimulus
    decision_t none;
    none = '0;
    // Extremes with results readable by hand; walks idle, forward warn,
    // partial, full, reverse warn and back to idle under reset settings.
    add_row(16'h0000, 16'h0000, 9'd0,   GEAR_OTHER_LO, 1'b0, 1'b1,
            MODE_IDLE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_row(16'hFFFF, 16'h0000, 9'd256, GEAR_DRIVE,    1'b0, 1'b1,
            MODE_FWD,  16'd0, 16'd16639, 16'd8447);
    add_row(16'hFFFF, 16'h0000, 9'd256, GEAR_DRIVE,    1'b0, 1'b1,
            MODE_PART, 16'd0, 16'd16639, 16'd8447);
    add_row(16'hFFFF, 16'h0000, 9'd256, GEAR_DRIVE,    1'b0, 1'b1,
            MODE_FULL, 16'd0, 16'd16639, 16'd8447);
    add_row(16'h0001, 16'hFFFF, 9'd256, GEAR_REVERSE,  1'b0, 1'b1,
            MODE_REV,  16'hFFFF, 16'd256, 16'd256);
    add_row(16'h0001, 16'hFFFF, 9'd256, GEAR_REVERSE,  1'b1, 1'b1,
            MODE_IDLE, 16'hFFFF, 16'd256, 16'd256);
    // Predicted rows: pedal overrides, gear other, each release path.
    add_row(16'hFFFF, 16'hFFFF, 9'd1,   GEAR_OTHER_HI, 1'b1, 1'b0, 0, 0, 0, 0);
    add_row(16'h8000, 16'h0100, 9'd256, GEAR_DRIVE,    1'b0, 1'b0, 0, 0, 0, 0);
    add_row(16'h0A00, 16'h0100, 9'd200, GEAR_DRIVE,    1'b1, 1'b0, 0, 0, 0, 0);
    add_row(16'h0A00, 16'h0100, 9'd200, GEAR_DRIVE,    1'b0, 1'b0, 0, 0, 0, 0);
    add_row(16'h0A00, 16'h0100, 9'd200, GEAR_DRIVE,    1'b1, 1'b0, 0, 0, 0, 0);
    add_row(16'h0A00, 16'h0300, 9'd200, GEAR_DRIVE,    1'b1, 1'b0, 0, 0, 0, 0);
    add_row(16'h0A00, 16'h0300, 9'd200, GEAR_DRIVE,    1'b1, 1'b0, 0, 0, 0, 0);
    add_row(16'h0A00, 16'h0100, 9'd200, GEAR_REVERSE,  1'b0, 1'b0, 0, 0, 0, 0);
    add_row(16'h0A00, 16'h0100, 9'd200, GEAR_REVERSE,  1'b0, 1'b0, 0, 0, 0, 0);
    add_row(16'h0A00, 16'h0200, 9'd200, GEAR_REVERSE,  1'b1, 1'b0, 0, 0, 0, 0);
    add_row(16'h0A00, 16'h0100, 9'd200, GEAR_REVERSE,  1'b0, 1'b0, 0, 0, 0, 0);
    add_row(16'h0A00, 16'h0100, 9'd200, GEAR_DRIVE,    1'b1, 1'b0, 0, 0, 0, 0);
    add_row(16'h0A00, 16'h0200, 9'd200, GEAR_DRIVE,    1'b1, 1'b0, 0, 0, 0, 0);
    add_row(16'h0A00, 16'h0300, 9'd200, GEAR_OTHER_LO, 1'b0, 1'b0, 0, 0, 0, 0);
    add_row(16'h0001, 16'h0000, 9'd1,   GEAR_DRIVE,    1'b0, 1'b0, 0, 0, 0, 0);
    add_row(16'h5555, 16'hAAAA, 9'h0AA, GEAR_DRIVE,    1'b0, 1'b0, 0, 0, 0, 0);
    add_row(16'hAAAA, 16'h5555, 9'h0FF, GEAR_REVERSE,  1'b1, 1'b0, 0, 0, 0, 0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_reading(directed_rows[i].rd, directed_rows[i].typed, directed_rows[i].want);
    // Keep the reset settings for the first random stretch.
    for (int n = 0; n < ITEMS_PER_PH; n++) send_reading(random_reading(), 1'b0, none);
    for (int ph = 1; ph <= PHASES; ph++) begin
      drain();
      apply_phase_config(ph);
      sender_calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PH; n++) send_reading(random_reading(), 1'b0, none);
    end
    drain();

    if (mismatch_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
